@@ sv/ntwa_pkg.sv @@
// Types and constants shared by the neighbor table controller and datapath.
// No dependencies.
package ntwa_pkg;

  localparam int unsigned EXPIRE_SECONDS = 30;
  localparam int unsigned MAX_RESULTS    = 64;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] ADDR_BCST    = 16'hFFFF;
  localparam logic [15:0] ADDR_INVALID = 16'h0000;

  typedef enum logic [1:0] {
    MODE_LEARN,
    MODE_ANNOUNCE,
    MODE_LEAVE,
    MODE_EXPIRE
  } mode_t;

  typedef enum logic [2:0] {
    EV_ADDED,
    EV_UPDATED,
    EV_LEFT,
    EV_EXPIRED,
    EV_FULL
  } event_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [31:0] last_seen;
    logic [31:0] metadata;
    logic [31:0] announce_date;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd;
    logic check;
    logic idx_inc;
    logic act;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic scan_end;
    logic is_expire;
    logic hit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

@@ sv/ntwa_ctrl.sv @@
// Sequencer of the neighbor table: clearing pass, table scan, action, flush.
// Depends on ntwa_pkg.
module ntwa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ntwa_pkg::stat_t stat,
  output ntwa_pkg::cmd_t  cmd
);
  import ntwa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ACT,
    S_FLUSH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // a second removal pushes the held one out: needs output space
        if (!(stat.is_expire && stat.hit && stat.pend_valid && !stat.out_free)) begin
          cmd.check = 1'b1;
          if (stat.scan_end) begin
            state_next = stat.is_expire ? S_FLUSH : S_ACT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_ACT: begin
        if (stat.out_free) begin
          cmd.act = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/ntwa_datapath.sv @@
// Neighbor table datapath: entry memory, item registers, lookup, aging
// compare, pending event and output register. Depends on ntwa_pkg.
module ntwa_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  ntwa_pkg::cmd_t  cmd,
  output ntwa_pkg::stat_t stat,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic [1:0]      s_axis_tuser,
  input  logic [111:0]    s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [2:0]      m_axis_tuser,
  output logic [15:0]     m_axis_tdata,
  output logic            m_axis_tlast
);
  import ntwa_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  logic [15:0] own_address;

  mode_t       item_mode;
  logic [15:0] item_addr;
  logic [31:0] item_now;
  logic [31:0] item_meta;
  logic [31:0] item_date;

  logic [IDX_W-1:0] idx;
  logic             found;
  logic [IDX_W-1:0] found_slot;
  entry_t           found_word;
  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic [CNT_W-1:0] cnt;

  logic        pend_valid;
  logic [15:0] pend_addr;

  logic we;
  logic [IDX_W-1:0] waddr;
  entry_t wdata;
  logic ev_valid;
  event_t ev_code;
  logic out_load;
  event_t out_code;
  logic [15:0] out_addr;
  logic out_last;
  logic exp_hit;
  logic lookup_match;
  logic leave_ok;
  logic [31:0] age;

  assign age = item_now - rd_q.last_seen;
  assign exp_hit = rd_q.valid &&
                   ((item_now == 32'd0) || (age >= EXPIRE_SECONDS));
  assign lookup_match = rd_q.valid && (rd_q.addr == item_addr);
  assign leave_ok = (item_addr != ADDR_BCST) && (item_addr != ADDR_INVALID) &&
                    (item_addr != own_address);

  always_comb begin
    stat.idx_last   = (idx == IDX_W'(TABLE_DEPTH - 1));
    stat.is_expire  = (item_mode == MODE_EXPIRE);
    stat.hit        = exp_hit;
    stat.scan_end   = stat.idx_last ||
                      (stat.is_expire && exp_hit && (cnt == CNT_W'(MAX_RESULTS - 1)));
    stat.pend_valid = pend_valid;
    stat.out_free   = !m_axis_tvalid || m_axis_tready;
  end

  // write port and event selection
  always_comb begin
    we       = 1'b0;
    waddr    = idx;
    wdata    = '0;
    ev_valid = 1'b0;
    ev_code  = EV_FULL;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.check && stat.is_expire && exp_hit) begin
      we = 1'b1;
      wdata = rd_q;
      wdata.valid = 1'b0;
    end else if (cmd.act) begin
      if (item_mode == MODE_LEAVE) begin
        we = found && leave_ok;
        waddr = found_slot;
        wdata = found_word;
        wdata.valid = 1'b0;
        ev_valid = we;
        ev_code = EV_LEFT;
      end else if (found) begin
        we = 1'b1;
        waddr = found_slot;
        wdata = found_word;
        wdata.last_seen = item_now;
        wdata.metadata = item_meta;
        if (item_mode == MODE_ANNOUNCE) wdata.announce_date = item_date;
        ev_valid = (item_mode == MODE_ANNOUNCE) && (found_word.announce_date != 32'd0);
        ev_code = EV_UPDATED;
      end else if (free_found) begin
        we = 1'b1;
        waddr = free_slot;
        wdata.valid = 1'b1;
        wdata.addr = item_addr;
        wdata.last_seen = item_now;
        wdata.metadata = item_meta;
        wdata.announce_date = (item_mode == MODE_ANNOUNCE) ? item_date : 32'd0;
        ev_valid = 1'b1;
        ev_code = EV_ADDED;
      end else begin
        ev_valid = 1'b1;
        ev_code = EV_FULL;
      end
    end
  end

  always_comb begin
    out_load = 1'b0;
    out_code = EV_EXPIRED;
    out_addr = pend_addr;
    out_last = 1'b0;
    if (cmd.check && stat.is_expire && exp_hit && pend_valid) begin
      out_load = 1'b1;
    end else if (cmd.flush && pend_valid) begin
      out_load = 1'b1;
      out_last = 1'b1;
    end else if (cmd.act && ev_valid) begin
      out_load = 1'b1;
      out_code = ev_code;
      out_addr = item_addr;
      out_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rd_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= mode_t'(s_axis_tuser);
      item_addr <= s_axis_tdata[15:0];
      item_now  <= s_axis_tdata[47:16];
      item_meta <= s_axis_tdata[79:48];
      item_date <= s_axis_tdata[111:80];
    end
    if (cmd.check && lookup_match && !found) begin
      found_slot <= idx;
      found_word <= rd_q;
    end
    if (cmd.check && !rd_q.valid && !free_found) free_slot <= idx;
    if (cmd.check && stat.is_expire && exp_hit) pend_addr <= rd_q.addr;
    if (out_load) begin
      m_axis_tuser <= out_code;
      m_axis_tdata <= out_addr;
      m_axis_tlast <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= 16'd0;
      idx           <= '0;
      found         <= 1'b0;
      free_found    <= 1'b0;
      cnt           <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) own_address <= cfg_wdata;
      if (cmd.load) begin
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.clear_wr || cmd.idx_inc) idx <= idx + 1'b1;
        if (cmd.check && lookup_match) found <= 1'b1;
        if (cmd.check && !rd_q.valid) free_found <= 1'b1;
        if (cmd.check && stat.is_expire && exp_hit) begin
          cnt <= cnt + 1'b1;
          pend_valid <= 1'b1;
        end else if (cmd.flush) begin
          pend_valid <= 1'b0;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while held");

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RESULTS))
    else $error("removal count beyond limit");

  assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (item_mode == MODE_EXPIRE))
    else $error("held event outside a sweep");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.act && cmd.check) && !(cmd.act && cmd.clear_wr))
    else $error("two write sources at once");

endmodule

@@ sv/neighbor_table_with_aging.sv @@
// Top level of the neighbor table with aging: controller plus datapath.
// Depends on ntwa_pkg, ntwa_ctrl, ntwa_datapath.
//
// Usage:
//   s_axis carries one operation per item: tuser is the mode (learn,
//   announce, leave, expire sweep); tdata packs peer address, time, link
//   metadata and announce date. m_axis returns zero or more events per item:
//   tuser is the event code, tdata the peer address, tlast marks the last
//   event of the item. cfg_we/cfg_wdata set the own address.
//   Every item scans the table through one memory read port, each entry
//   read in S_READ and checked in S_CHECK; an expire sweep stops early once
//   it has removed MAX_RESULTS entries. A sweep stalls when the receiver
//   stalls, since each removal beyond the first waits for the output
//   register. A new item is accepted only after the previous one is done.
//   After reset the block runs a clearing pass over every memory entry
//   with s_axis_tready low. A stalled receiver simply holds the output
//   register; nothing is dropped.
module neighbor_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,     // own_address
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // mode
  input  logic [111:0] s_axis_tdata,  // peer_address, now_seconds, link_metadata, announce_date
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [2:0]   m_axis_tuser,  // event_code
  output logic [15:0]  m_axis_tdata,  // event_address
  output logic         m_axis_tlast   // last_of_run
);
  import ntwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ntwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntwa_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ bench/neighbor_table_with_aging_tb.sv @@
// Self-checking testbench for neighbor_table_with_aging: directed table, table-full and
// full-sweep cases, then random learn/announce/leave/expire traffic with stalls on both sides.
// Depends on ntwa_pkg and the neighbor_table_with_aging RTL.
module neighbor_table_with_aging_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ntwa_pkg::*;

  localparam int unsigned TABLE_SLOTS  = 64;
  localparam int unsigned SWEEP_CAP    = 64;
  localparam int unsigned IDLE_LIMIT_S = 30;
  localparam logic [15:0] PEER_BCST    = 16'hFFFF;
  localparam logic [15:0] PEER_NONE    = 16'h0000;
  localparam int          BUSY_CYCLES  = 2 * TABLE_SLOTS + 40;
  localparam int          STUCK_LIMIT  = 4000;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] addr;
    logic [31:0] now;
    logic [31:0] meta;
    logic [31:0] date;
  } op_t;

  typedef struct packed {
    event_t      code;
    logic [15:0] addr;
    logic        last;
  } peer_event_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    op_t         op;
    chk_t        chk;
    event_t      code;
    logic [15:0] ev_addr;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;   // mode
  logic [111:0] s_axis_tdata = '0;   // peer_address, now_seconds, link_metadata, announce_date
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [2:0]   m_axis_tuser;        // event_code
  logic [15:0]  m_axis_tdata;        // event_address
  logic         m_axis_tlast;        // last_of_run

  neighbor_table_with_aging #(.TABLE_DEPTH(TABLE_SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // shadow of the peer table
  logic        nt_valid [TABLE_SLOTS];
  logic [15:0] nt_addr  [TABLE_SLOTS];
  logic [31:0] nt_seen  [TABLE_SLOTS];
  logic [31:0] nt_date  [TABLE_SLOTS];
  logic [15:0] own_addr_m = '0;

  peer_event_t step_events [$];
  peer_event_t pending_events [$];
  int          errors = 0;
  int          burst_left = 0;
  logic [31:0] clock_s;

  // ---------------------------------------------------------------- watchdog
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STUCK_LIMIT);
        $display("** neighbor_table_with_aging: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls
  int       rx_cycle = 0;
  logic [1:0] rx_style = '0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_style <= 2'($urandom_range(0, 3));
    case (rx_style)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rx_cycle % 16) < 10);
    endcase
  end

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    peer_event_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{code: event_t'(m_axis_tuser), addr: m_axis_tdata, last: m_axis_tlast};
      if (pending_events.size() == 0) begin
        errors <= errors + 1;
        if (errors < 50)
          $display("%0t: unexpected event: got code=%0d addr=%h last=%b",
                   $realtime, got.code, got.addr, got.last);
      end else begin
        want = pending_events.pop_front();
        if (got.code !== want.code || got.addr !== want.addr || got.last !== want.last) begin
          errors <= errors + 1;
          if (errors < 50)
            $display({"%0t: mismatch: expected code=%0d addr=%h last=%b, ",
                      "got code=%0d addr=%h last=%b"},
                     $realtime, want.code, want.addr, want.last, got.code, got.addr, got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int lookup_peer(logic [15:0] addr);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (nt_valid[i] && nt_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic void table_update(op_t op);
    int          slot;
    logic        had_date;
    logic [31:0] age;
    step_events.delete();
    case (op.mode)
      MODE_LEARN, MODE_ANNOUNCE: begin
        slot = lookup_peer(op.addr);
        if (slot < 0) begin
          for (int i = TABLE_SLOTS - 1; i >= 0; i--)
            if (!nt_valid[i]) slot = i;
          if (slot < 0) begin
            step_events.push_back('{code: EV_FULL, addr: op.addr, last: 1'b0});
          end else begin
            nt_valid[slot] = 1'b1;
            nt_addr[slot]  = op.addr;
            nt_date[slot]  = '0;
            step_events.push_back('{code: EV_ADDED, addr: op.addr, last: 1'b0});
          end
        end
        if (slot >= 0) begin
          nt_seen[slot] = op.now;
          if (op.mode == MODE_ANNOUNCE) begin
            had_date      = (nt_date[slot] != 0);
            nt_date[slot] = op.date;
            if (had_date) step_events.push_back('{code: EV_UPDATED, addr: op.addr, last: 1'b0});
          end
        end
      end
      MODE_LEAVE: begin
        if (op.addr != PEER_BCST && op.addr != PEER_NONE && op.addr != own_addr_m) begin
          slot = lookup_peer(op.addr);
          if (slot >= 0) begin
            nt_valid[slot] = 1'b0;
            step_events.push_back('{code: EV_LEFT, addr: op.addr, last: 1'b0});
          end
        end
      end
      default: begin
        for (int i = 0; i < TABLE_SLOTS && step_events.size() < SWEEP_CAP; i++) begin
          age = op.now - nt_seen[i];
          if (nt_valid[i] && (op.now == 0 || age >= IDLE_LIMIT_S)) begin
            nt_valid[i] = 1'b0;
            step_events.push_back('{code: EV_EXPIRED, addr: nt_addr[i], last: 1'b0});
          end
        end
      end
    endcase
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  task automatic send_op(op_t op);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.mode;
    s_axis_tdata  <= {op.date, op.meta, op.now, op.addr};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic issue(op_t op);
    send_op(op);
    table_update(op);
    foreach (step_events[j]) pending_events.push_back(step_events[j]);
  endtask

  // drain all events, then give a no-event item time to finish its scan
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  task automatic set_own(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    own_addr_m = value;
  endtask

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'($urandom);
    if (r < 12) return PEER_BCST;
    if (r < 16) return PEER_NONE;
    if (r < 22) return own_addr_m;
    return 16'h0100 + 16'($urandom_range(0, 79));
  endfunction

  task automatic run_random(int count);
    op_t op;
    int  r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      op.mode = (r < 35) ? MODE_LEARN : (r < 65) ? MODE_ANNOUNCE :
                (r < 82) ? MODE_LEAVE : MODE_EXPIRE;
      if ($urandom_range(0, 6) == 0) clock_s += $urandom_range(1, 24);
      op.addr = pick_addr();
      op.meta = $urandom;
      op.date = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
      op.now  = clock_s;
      r = $urandom_range(0, 11);
      if (r == 0) op.now = $urandom;
      else if (r == 1 && op.mode == MODE_EXPIRE) op.now = '0;
      if ($urandom_range(0, 29) == 0) wait_idle();
      issue(op);
    end
  endtask

  // ---------------------------------------------------------------- directed rows
  dir_row_t dir_rows [25] = '{
    '{'{MODE_LEAVE, 16'h0005, 32'd0, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_EXPIRE, 16'h0000, 32'd0, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEARN, 16'h0001, 32'd100, 32'hFFFFFFFF, 32'd0}, CHK_ONE, EV_ADDED, 16'h0001},
    '{'{MODE_ANNOUNCE, 16'h0001, 32'd110, 32'd0, 32'h12345678}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_ANNOUNCE, 16'h0001, 32'd120, 32'd5, 32'hFFFFFFFF}, CHK_ONE, EV_UPDATED, 16'h0001},
    '{'{MODE_ANNOUNCE, 16'hFFFF, 32'hFFFFFFFF, 32'd0, 32'd0}, CHK_ONE, EV_ADDED, 16'hFFFF},
    '{'{MODE_ANNOUNCE, 16'hFFFF, 32'hFFFFFFFF, 32'd1, 32'd5}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_ANNOUNCE, 16'hFFFF, 32'hFFFFFFFF, 32'd2, 32'd6}, CHK_ONE, EV_UPDATED, 16'hFFFF},
    '{'{MODE_LEARN, 16'h0000, 32'd130, 32'd3, 32'd0}, CHK_ONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEARN, 16'h1234, 32'd130, 32'd4, 32'd0}, CHK_ONE, EV_ADDED, 16'h1234},
    '{'{MODE_LEARN, 16'h1234, 32'd135, 32'd5, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEAVE, 16'hFFFF, 32'd136, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEAVE, 16'h0000, 32'd136, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEAVE, 16'h1234, 32'd136, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_LEAVE, 16'h0001, 32'd136, 32'd0, 32'd0}, CHK_ONE, EV_LEFT, 16'h0001},
    '{'{MODE_LEAVE, 16'h0001, 32'd137, 32'd0, 32'd0}, CHK_NONE, EV_ADDED, 16'h0000},
    '{'{MODE_ANNOUNCE, 16'h0001, 32'd140, 32'd6, 32'd9}, CHK_ONE, EV_ADDED, 16'h0001},
    '{'{MODE_ANNOUNCE, 16'h0001, 32'd150, 32'd7, 32'd10}, CHK_ONE, EV_UPDATED, 16'h0001},
    '{'{MODE_LEARN, 16'h0777, 32'hFFFFFFF0, 32'd8, 32'd0}, CHK_ONE, EV_ADDED, 16'h0777},
    '{'{MODE_EXPIRE, 16'h0000, 32'h0000000D, 32'd0, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000},
    '{'{MODE_EXPIRE, 16'h0000, 32'h0000000E, 32'd0, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000},
    '{'{MODE_LEARN, 16'h0042, 32'h00000010, 32'hAAAAAAAA, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000},
    '{'{MODE_EXPIRE, 16'h0000, 32'd0, 32'd0, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000},
    '{'{MODE_LEARN, 16'h0777, 32'd200, 32'h55555555, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000},
    '{'{MODE_EXPIRE, 16'h0000, 32'd230, 32'd0, 32'd0}, CHK_MODEL, EV_ADDED, 16'h0000}
  };

  // ---------------------------------------------------------------- sequence
  initial begin
    foreach (nt_valid[i]) nt_valid[i] = 1'b0;
    clock_s = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_own(16'h1234);

    foreach (dir_rows[r]) begin
      send_op(dir_rows[r].op);
      table_update(dir_rows[r].op);
      case (dir_rows[r].chk)
        CHK_MODEL: foreach (step_events[j]) pending_events.push_back(step_events[j]);
        CHK_ONE:   pending_events.push_back('{code: dir_rows[r].code, addr: dir_rows[r].ev_addr,
                                              last: 1'b1});
        default: ;
      endcase
    end
    wait_idle();

    // fill the table, overflow it, then sweep every slot at once
    set_own(16'hFFFF);
    for (int i = 0; i < TABLE_SLOTS; i++)
      issue('{MODE_LEARN, 16'h2000 + 16'(i), 32'd1000 + 32'(i), 32'($urandom), 32'd0});
    issue('{MODE_LEARN,    16'h3000, 32'd1100, 32'd1, 32'd0});
    issue('{MODE_ANNOUNCE, 16'h3001, 32'd1100, 32'd2, 32'd3});
    issue('{MODE_ANNOUNCE, 16'h2005, 32'd1100, 32'd3, 32'd3});
    issue('{MODE_LEAVE,    16'h2007, 32'd1100, 32'd0, 32'd0});
    issue('{MODE_LEARN,    16'h3000, 32'd1100, 32'd4, 32'd0});
    issue('{MODE_EXPIRE,   16'h0000, 32'd2000, 32'd0, 32'd0});
    run_random(62);
    wait_idle();

    set_own(16'h0000);
    run_random(62);
    wait_idle();

    set_own(16'h0100 + 16'($urandom_range(0, 79)));
    run_random(62);

    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES * 2) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("** neighbor_table_with_aging: PASSED **");
    end else begin
      $display("** neighbor_table_with_aging: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ntwa_pkg.sv
sv/ntwa_ctrl.sv
sv/ntwa_datapath.sv
sv/neighbor_table_with_aging.sv
bench/neighbor_table_with_aging_tb.sv
